// ----- hw/rtl/ecfe_pkg.sv -----
`default_nettype none

package ecfe_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned NUM_BYTES = WORD_W / BYTE_W;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_ABORT = 2'd2
  } action_e;

endpackage

`default_nettype wire

// ----- hw/rtl/ecfe_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module ecfe_div #(
  parameter int unsigned QW = 17,
  localparam int unsigned CW = $clog2(QW + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [CW-1:0]               steps_i,
  input  wire logic [ecfe_pkg::WORD_W-1:0] rem_i,
  input  wire logic [QW-1:0]               bits_i,
  input  wire logic [ecfe_pkg::WORD_W-1:0] divisor_i,
  output logic                             done_o,
  output logic [QW-1:0]                    quo_o
);
  import ecfe_pkg::*;

  logic [WORD_W-1:0] rem_q;
  logic [WORD_W-1:0] div_q;
  logic [QW-1:0]     bits_q;
  logic [QW-1:0]     quo_q;
  logic [CW-1:0]     cnt_q;
  logic              run_q;
  logic              done_q;

  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;
  logic              ge;

  always_comb begin
    trial = {rem_q, bits_q[QW-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      div_q  <= '0;
      bits_q <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      rem_q  <= rem_i;
      div_q  <= divisor_i;
      bits_q <= bits_i;
      quo_q  <= '0;
      cnt_q  <= steps_i;
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      rem_q  <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      bits_q <= {bits_q[QW-2:0], 1'b0};
      quo_q  <= {quo_q[QW-2:0], ge};
      cnt_q  <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ----- hw/rtl/eased_color_fade_engine.sv -----
`default_nettype none

// Eased RGBW fade engine. A start beat freezes the color reached at now_ms and
// begins a fade toward goal_color over fade_ms; tick beats advance it along
// r^2/(2r^2-2r+1) and report the shown color, a refresh flag and busy. One beat
// is taken at a time. A tick during a fade, or a start, runs one bit-serial
// divider twice (elapsed/duration, then the easing quotient), followed by one
// multiply per color byte; once the duration has passed the divisions are
// skipped. Other beats go straight to the write step. A finished result waits
// in an output register while the next beat is taken; a beat that finishes
// while that register is still stalled waits until it frees.
module eased_color_fade_engine #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  action_i,
  input  wire logic [ecfe_pkg::WORD_W-1:0] now_ms_i,
  input  wire logic [ecfe_pkg::WORD_W-1:0] goal_color_i,
  input  wire logic [ecfe_pkg::WORD_W-1:0] fade_ms_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [ecfe_pkg::WORD_W-1:0]      shown_color_o,
  output logic                             refresh_o,
  output logic                             busy_res_o
);
  import ecfe_pkg::*;

  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(QW + 1);
  localparam logic [QW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROG,
    ST_WAIT1,
    ST_SQUARE,
    ST_DPREP,
    ST_WAIT2,
    ST_BLEND,
    ST_WRITE
  } state_e;

  state_e            state_q;
  logic [1:0]        act_q;
  logic [WORD_W-1:0] now_q;
  logic [WORD_W-1:0] goal_q;
  logic [WORD_W-1:0] dur_q;

  logic [WORD_W-1:0] from_q;
  logic [WORD_W-1:0] to_q;
  logic [WORD_W-1:0] begin_q;
  logic [WORD_W-1:0] span_q;
  logic              finished_q;
  logic [WORD_W-1:0] last_q;

  logic [FRAC_BITS-1:0] r_q;
  logic [FRAC_BITS-1:0] r2_q;
  logic [QW-1:0]        p_q;
  logic [WORD_W-1:0]    col_q;
  logic [1:0]           k_q;

  logic              out_valid_q;
  logic [WORD_W-1:0] shown_q;
  logic              refresh_q;
  logic              busy_q;

  // datapath
  logic [WORD_W-1:0]      dt;
  logic                   dt_ge;
  logic [2*FRAC_BITS-1:0] sq;
  logic [FRAC_BITS+1:0]   dval;
  logic                   div_start;
  logic [CW-1:0]          div_steps;
  logic [WORD_W-1:0]      div_rem;
  logic [QW-1:0]          div_bits;
  logic [WORD_W-1:0]      div_divisor;
  logic                   div_done;
  logic [QW-1:0]          div_quo;

  logic [BYTE_W-1:0]       tb;
  logic [BYTE_W-1:0]       sb;
  logic signed [BYTE_W:0]  bdiff;
  logic signed [QW:0]      pmul;
  logic signed [QW+BYTE_W:0] prod;
  logic signed [QW+BYTE_W:0] prod_sh;
  logic [BYTE_W-1:0]       vbyte;

  logic              slot_free;
  logic [WORD_W-1:0] wr_last;
  logic              wr_fin;
  logic              wr_refresh;

  always_comb begin
    dt    = now_q - begin_q;
    dt_ge = (dt >= span_q);
    sq    = r_q * r_q;
    dval  = {1'b0, r2_q, 1'b0} + {1'b0, ONE} - {1'b0, r_q, 1'b0};

    div_start   = ((state_q == ST_PROG) && !dt_ge) || (state_q == ST_DPREP);
    div_steps   = (state_q == ST_DPREP) ? CW'(QW) : CW'(FRAC_BITS);
    div_rem     = (state_q == ST_DPREP) ? {{(WORD_W - FRAC_BITS + 1){1'b0}},
                                           r2_q[FRAC_BITS-1:1]} : dt;
    div_bits    = (state_q == ST_DPREP) ? {r2_q[0], {FRAC_BITS{1'b0}}} : '0;
    div_divisor = (state_q == ST_DPREP) ? {{(WORD_W - FRAC_BITS - 2){1'b0}}, dval}
                                        : span_q;

    tb      = to_q[{k_q, 3'b000} +: BYTE_W];
    sb      = from_q[{k_q, 3'b000} +: BYTE_W];
    bdiff   = $signed({1'b0, tb}) - $signed({1'b0, sb});
    pmul    = $signed({1'b0, p_q});
    prod    = bdiff * pmul;
    prod_sh = prod >>> FRAC_BITS;
    vbyte   = sb + prod_sh[BYTE_W-1:0];

    slot_free = !out_valid_q || !out_stall_i;

    wr_last    = last_q;
    wr_fin     = finished_q;
    wr_refresh = 1'b0;
    case (act_q)
      ACT_TICK: begin
        if (!finished_q) begin
          if (p_q == ONE) begin
            wr_fin = 1'b1;
          end
          if (col_q != last_q) begin
            wr_last    = col_q;
            wr_refresh = 1'b1;
          end
        end
      end
      ACT_START: begin
        wr_fin = 1'b0;
      end
      ACT_ABORT: begin
        wr_fin = 1'b1;
      end
      default: begin
        wr_fin = finished_q;
      end
    endcase
  end

  ecfe_div #(
    .QW(QW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .steps_i   (div_steps),
    .rem_i     (div_rem),
    .bits_i    (div_bits),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quo_o     (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      act_q       <= '0;
      now_q       <= '0;
      goal_q      <= '0;
      dur_q       <= '0;
      from_q      <= '0;
      to_q        <= '0;
      begin_q     <= '0;
      span_q      <= '0;
      finished_q  <= 1'b1;
      last_q      <= '0;
      r_q         <= '0;
      r2_q        <= '0;
      p_q         <= '0;
      col_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      shown_q     <= '0;
      refresh_q   <= 1'b0;
      busy_q      <= 1'b0;
    end else begin
      if ((state_q == ST_WRITE) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            act_q  <= action_i;
            now_q  <= now_ms_i;
            goal_q <= goal_color_i;
            dur_q  <= fade_ms_i;
            if ((action_i == ACT_START) || ((action_i == ACT_TICK) && !finished_q)) begin
              state_q <= ST_PROG;
            end else begin
              state_q <= ST_WRITE;
            end
          end
        end
        ST_PROG: begin
          k_q <= '0;
          if (dt_ge) begin
            p_q     <= ONE;
            state_q <= ST_BLEND;
          end else begin
            state_q <= ST_WAIT1;
          end
        end
        ST_WAIT1: begin
          if (div_done) begin
            r_q     <= div_quo[FRAC_BITS-1:0];
            state_q <= ST_SQUARE;
          end
        end
        ST_SQUARE: begin
          r2_q    <= sq[2*FRAC_BITS-1:FRAC_BITS];
          state_q <= ST_DPREP;
        end
        ST_DPREP: begin
          state_q <= ST_WAIT2;
        end
        ST_WAIT2: begin
          if (div_done) begin
            p_q     <= (div_quo > ONE) ? ONE : div_quo;
            state_q <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          col_q[{k_q, 3'b000} +: BYTE_W] <= vbyte;
          k_q <= k_q + 2'd1;
          if (k_q == 2'd3) begin
            state_q <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (slot_free) begin
            if (act_q == ACT_START) begin
              from_q  <= col_q;
              to_q    <= goal_q;
              begin_q <= now_q;
              span_q  <= dur_q;
            end
            last_q      <= wr_last;
            finished_q  <= wr_fin;
            shown_q     <= wr_last;
            refresh_q   <= wr_refresh;
            busy_q      <= !wr_fin;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_valid_q;
  assign shown_color_o = shown_q;
  assign refresh_o     = refresh_q;
  assign busy_res_o    = busy_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ecfe_checker.sv -----
`default_nettype none

module ecfe_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [ecfe_pkg::WORD_W-1:0] shown_color_o,
  input wire logic                        refresh_o,
  input wire logic                        busy_res_o
);
  import ecfe_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(shown_color_o) &&
                                   $stable(refresh_o) && $stable(busy_res_o))
    else $error("stalled result beat changed");

  // one beat at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a beat is in flight");

  // a new result only comes out of a beat in flight
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without an accepted beat");

  // finishing a beat always leaves a result
  a_finish_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("beat finished without a result");

  // a refresh follows a tick, which needs a running fade
  a_refresh_needs_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && refresh_o |-> $past(in_stall_o, 2) || $past(busy_res_o))
    else $error("refresh without a running fade");

endmodule

bind eased_color_fade_engine ecfe_checker u_ecfe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .shown_color_o (shown_color_o),
  .refresh_o     (refresh_o),
  .busy_res_o    (busy_res_o)
);

`default_nettype wire
